// File: rtl/core/tscrm_pkg.sv
package tscrm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RAMP_SELECT   = 2'd0,
    REG_HUE_SHIFT     = 2'd1,
    REG_GAIN_LEVEL    = 2'd2,
    REG_STRETCH_LEVEL = 2'd3
  } cfg_reg_t;

  // ramp codes, the unused code falls back to the warm ramp
  localparam logic [1:0] RAMP_COOL    = 2'd0;
  localparam logic [1:0] RAMP_PHOSPHOR = 2'd1;
  localparam logic [1:0] RAMP_WARM    = 2'd2;

  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned LEVEL_W    = 10;

  // reset values of the registers
  localparam logic [1:0]         RAMP_SELECT_RST   = RAMP_WARM;
  localparam logic [LEVEL_W-1:0] HUE_SHIFT_RST     = 10'd0;
  localparam logic [LEVEL_W-1:0] GAIN_LEVEL_RST    = 10'd500;
  localparam logic [LEVEL_W-1:0] STRETCH_LEVEL_RST = 10'd500;

  // position arithmetic
  localparam logic [10:0] POS_MOD     = 11'd1001;
  localparam logic [10:0] POS_MOD_X2  = 11'd2002;
  localparam logic [9:0]  POS_MID     = 10'd500;
  localparam logic [10:0] LEVEL_BIAS  = 11'd500;
  localparam logic signed [9:0]  MID_GRAY    = 10'sd128;
  localparam logic signed [10:0] MID_GRAY_W  = 11'sd128;
  localparam logic signed [10:0] BYTE_MAX_W  = 11'sd255;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // truncating divide by 1000: floor(x * RECIP / 2^RECIP_SHIFT) is exact for x < 2^20
  localparam int unsigned DIV_IN_W    = 20;
  localparam int unsigned DIV_OUT_W   = 10;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [DIV_IN_W-1:0] RECIP = 20'd536871;

  // stop colors, indexed [ramp][stop][channel], stops low/mid/high, channels r/g/b
  localparam logic [7:0] RAMP_TBL [3][3][3] = '{
    '{ '{8'd8,   8'd28,  8'd60},  '{8'd44,  8'd132, 8'd188}, '{8'd186, 8'd242, 8'd214} },
    '{ '{8'd6,   8'd24,  8'd10},  '{8'd42,  8'd148, 8'd52},  '{8'd190, 8'd255, 8'd170} },
    '{ '{8'd72,  8'd32,  8'd76},  '{8'd144, 8'd70,  8'd154}, '{8'd255, 8'd196, 8'd92} }
  };

endpackage

// File: rtl/core/tscrm_div1000.sv
module tscrm_div1000 (
  input  logic clk,
  input  logic en,
  input  logic signed [tscrm_pkg::DIV_IN_W-1:0]  num,
  output logic signed [tscrm_pkg::DIV_OUT_W-1:0] quo
);
  import tscrm_pkg::*;

  logic                    neg;
  logic [DIV_IN_W-1:0]     mag;
  logic [2*DIV_IN_W-1:0]   prod;
  logic [DIV_OUT_W-1:0]    q_r;
  logic                    neg_r;

  // divide the magnitude, sign goes back on afterwards (truncation toward zero)
  always_comb begin
    neg  = num[DIV_IN_W-1];
    mag  = neg ? DIV_IN_W'(-num) : DIV_IN_W'(num);
    prod = (2*DIV_IN_W)'(mag) * (2*DIV_IN_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= prod[RECIP_SHIFT +: DIV_OUT_W];
      neg_r <= neg;
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// File: rtl/core/three_stop_color_ramp_mapper_core.sv
// Three-stop color ramp mapper: turns one field sample (per mille) into one RGBA word.
// The sample plus hue_shift, modulo 1001, places the pixel on the selected ramp; the
// color blends low-to-mid or mid-to-high, then each channel gets the brightness gain
// (gain_level+500)/1000 and the contrast stretch about 128 by (stretch_level+500)/1000,
// and clamps to 0..255. Alpha is always 255. Every divide by 1000 truncates toward zero.
// Throughput is one word per clock while out_tready keeps the output drained; a word reaches
// out_tvalid through nine register stages (ramp lookup, blend multiply, blend divide,
// blend add, brightness multiply and divide, contrast multiply and divide, clamp), each
// divide by 1000 done as a reciprocal multiply. The whole pipeline holds while the output
// word waits, so out_tready low with a word waiting stalls the input side at once, even
// with bubbles still in the pipeline. Configuration writes act at once and must be made
// while the pipeline is empty. No state beyond the four registers; ramp_select 3 maps to
// the warm ramp.
module three_stop_color_ramp_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sample, [15:10] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [tscrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tscrm_pkg::*;

  localparam int unsigned NCH = 3;

  // configuration registers
  logic [1:0]         ramp_select_r;
  logic [LEVEL_W-1:0] hue_shift_r;
  logic [LEVEL_W-1:0] gain_level_r;
  logic [LEVEL_W-1:0] stretch_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_select_r   <= RAMP_SELECT_RST;
      hue_shift_r     <= HUE_SHIFT_RST;
      gain_level_r    <= GAIN_LEVEL_RST;
      stretch_level_r <= STRETCH_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RAMP_SELECT:   ramp_select_r   <= cfg_data[1:0];
        REG_HUE_SHIFT:     hue_shift_r     <= cfg_data[LEVEL_W-1:0];
        REG_GAIN_LEVEL:    gain_level_r    <= cfg_data[LEVEL_W-1:0];
        REG_STRETCH_LEVEL: stretch_level_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves when the output register is free or drained
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // valid bits for stages a..h, output stage is out_tvalid
  logic [7:0] vld_r;
  logic [7:0] vld_nxt;
  logic       out_vld_r;

  assign vld_nxt = {vld_r[6:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= vld_nxt;
      out_vld_r <= vld_r[7];
    end
  end
  assign out_tvalid = out_vld_r;

  // stage a: ramp position, segment, blend amount and stop pair per channel
  logic [10:0]       pos_sum;
  logic [10:0]       pos_w;
  logic [9:0]        pos;
  logic              upper;
  logic [9:0]        amt_nxt;
  logic [1:0]        rsel;
  logic [7:0]        a_nxt [NCH];
  logic signed [8:0] d_nxt [NCH];

  logic [9:0]        amt_a_r;
  logic [7:0]        a_a_r [NCH];
  logic signed [8:0] d_a_r [NCH];

  always_comb begin
    pos_sum = {1'b0, in_tdata[9:0]} + {1'b0, hue_shift_r};
    if (pos_sum >= POS_MOD_X2) begin
      pos_w = pos_sum - POS_MOD_X2;
    end else if (pos_sum >= POS_MOD) begin
      pos_w = pos_sum - POS_MOD;
    end else begin
      pos_w = pos_sum;
    end
    pos     = pos_w[9:0];
    upper   = pos > POS_MID;
    amt_nxt = upper ? 10'((pos - POS_MID) << 1) : 10'(pos << 1);
    rsel    = (ramp_select_r == RAMP_COOL || ramp_select_r == RAMP_PHOSPHOR) ?
              ramp_select_r : RAMP_WARM;
    for (int ch = 0; ch < NCH; ch++) begin
      a_nxt[ch] = upper ? RAMP_TBL[rsel][1][ch] : RAMP_TBL[rsel][0][ch];
      d_nxt[ch] = upper ?
                  $signed({1'b0, RAMP_TBL[rsel][2][ch]}) - $signed({1'b0, RAMP_TBL[rsel][1][ch]}) :
                  $signed({1'b0, RAMP_TBL[rsel][1][ch]}) - $signed({1'b0, RAMP_TBL[rsel][0][ch]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amt_a_r <= amt_nxt;
      for (int ch = 0; ch < NCH; ch++) begin
        a_a_r[ch] <= a_nxt[ch];
        d_a_r[ch] <= d_nxt[ch];
      end
    end
  end

  // gain and stretch factors; the user must keep them stable while items are in flight, the block does not enforce it
  logic [10:0] gain;
  logic [10:0] stretch;
  assign gain    = {1'b0, gain_level_r} + LEVEL_BIAS;
  assign stretch = {1'b0, stretch_level_r} + LEVEL_BIAS;

  logic [7:0] red, green, blue;

  // per-channel lanes
  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    logic signed [DIV_IN_W-1:0]  blend_prod_b_r;
    logic [7:0]                  a_b_r;
    logic [7:0]                  a_c_r;
    logic signed [DIV_OUT_W-1:0] blend_q;
    logic signed [DIV_OUT_W-1:0] c_sum;
    logic [7:0]                  c_d_r;
    logic [18:0]                 gain_prod_e_r;
    logic signed [DIV_OUT_W-1:0] gain_q;
    logic signed [DIV_OUT_W-1:0] dev;
    logic signed [DIV_IN_W-1:0]  str_prod_g_r;
    logic signed [DIV_OUT_W-1:0] str_q;
    logic signed [10:0]          pix;
    logic [7:0]                  byte_i_r;

    // stage b: ramp difference times blend amount
    always_ff @(posedge clk) begin
      if (en) begin
        blend_prod_b_r <= $signed({{(DIV_IN_W-9){d_a_r[ch][8]}}, d_a_r[ch]}) *
                          $signed({{(DIV_IN_W-10){1'b0}}, amt_a_r});
        a_b_r          <= a_a_r[ch];
      end
    end

    // stage c: blend quotient
    tscrm_div1000 u_div_blend (
      .clk (clk),
      .en  (en),
      .num (blend_prod_b_r),
      .quo (blend_q)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        a_c_r <= a_b_r;
      end
    end

    // stage d: blended channel, always lands in 0..255
    assign c_sum = $signed({2'b00, a_c_r}) + blend_q;

    always_ff @(posedge clk) begin
      if (en) begin
        c_d_r <= c_sum[7:0];
      end
    end

    // stage e: brightness product
    always_ff @(posedge clk) begin
      if (en) begin
        gain_prod_e_r <= 19'(c_d_r) * 19'(gain);
      end
    end

    // stage f: brightness quotient
    tscrm_div1000 u_div_gain (
      .clk (clk),
      .en  (en),
      .num ($signed({1'b0, gain_prod_e_r})),
      .quo (gain_q)
    );

    // stage g: deviation from mid gray times contrast factor
    assign dev = gain_q - MID_GRAY;

    always_ff @(posedge clk) begin
      if (en) begin
        str_prod_g_r <= $signed({{(DIV_IN_W-DIV_OUT_W){dev[DIV_OUT_W-1]}}, dev}) *
                        $signed({{(DIV_IN_W-11){1'b0}}, stretch});
      end
    end

    // stage h: contrast quotient
    tscrm_div1000 u_div_stretch (
      .clk (clk),
      .en  (en),
      .num (str_prod_g_r),
      .quo (str_q)
    );

    // output stage: recenter and clamp to a byte
    assign pix = $signed({str_q[DIV_OUT_W-1], str_q}) + MID_GRAY_W;

    always_ff @(posedge clk) begin
      if (en) begin
        if (pix < 0) begin
          byte_i_r <= 8'd0;
        end else if (pix > BYTE_MAX_W) begin
          byte_i_r <= 8'd255;
        end else begin
          byte_i_r <= pix[7:0];
        end
      end
    end
  end

  assign red   = g_lane[0].byte_i_r;
  assign green = g_lane[1].byte_i_r;
  assign blue  = g_lane[2].byte_i_r;

  assign out_tdata = {ALPHA_OPAQUE, blue, green, red};

endmodule
